// ===== rtl/csc_pkg.sv =====
package csc_pkg;

	// Flags byte bit positions
	localparam int FLAG_WHEEL = 0;
	localparam int FLAG_CRANK = 1;

	// Section lengths in bytes
	localparam logic [3:0] WHEEL_BYTES = 4'd6;
	localparam logic [3:0] CRANK_BYTES = 4'd4;
	localparam logic [3:0] POS_MAX     = 4'd15;

	// Speed: revs * circ * 36864 / (dt * 100), with 36864 = 9 << 12
	localparam logic [22:0] SPEED_DIV = 23'd100;
	localparam logic [15:0] SPEED_SAT = 16'hFFFF;

	// Cadence: revs * 6144000 / dt, with 6144000 = 375 << 14
	localparam logic [15:0] CAD_MUL = 16'd375;

	// Shared divider: 23-bit divisor, 16 quotient bits
	localparam int DIV_W  = 23;
	localparam int DIV_Q  = 16;
	localparam int DIV_CW = $clog2(DIV_Q + 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WHEEL_CIRC = 2'd0,
		REG_CAD_MAX    = 2'd1,
		REG_CAD_MIN    = 2'd2,
		REG_MISS_LIMIT = 2'd3
	} cfg_reg_t;

	localparam logic [11:0] RST_WHEEL_CIRC = 12'd2095;
	localparam logic [14:0] RST_CAD_MAX    = 15'd20000;
	localparam logic [14:0] RST_CAD_MIN    = 15'd100;
	localparam logic [1:0]  RST_MISS_LIMIT = 2'd2;

	typedef struct packed {
		logic [11:0] wheel_circ;
		logic [14:0] cad_max;
		logic [14:0] cad_min;
		logic [1:0]  miss_limit;
	} cfg_t;

	// One parsed packet, handed from the front end to the back end
	typedef struct packed {
		logic        wheel_ok;
		logic        crank_ok;
		logic        short_pkt;
		logic [31:0] wheel_count;
		logic [15:0] wheel_time;
		logic [15:0] crank_count;
		logic [15:0] crank_time;
	} pkt_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/csc_div.sv =====
module csc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [csc_pkg::DIV_W-1:0]  rem_init,
	input  logic [csc_pkg::DIV_Q-1:0]  low_init,
	input  logic [csc_pkg::DIV_W-1:0]  divisor,
	output csc_pkg::div_stat_t         stat,
	output logic [csc_pkg::DIV_Q-1:0]  quot
);

	logic [csc_pkg::DIV_CW-1:0] cnt_q;
	logic                       done_q;
	logic [csc_pkg::DIV_W-1:0]  rem_q;
	logic [csc_pkg::DIV_Q-1:0]  low_q;
	logic [csc_pkg::DIV_W-1:0]  dvsr_q;
	logic [csc_pkg::DIV_W:0]    trial;
	logic                       ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, low_q[csc_pkg::DIV_Q-1]};
	assign ge    = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == csc_pkg::DIV_CW'(1));
			if (start) begin
				cnt_q <= csc_pkg::DIV_CW'(csc_pkg::DIV_Q);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - csc_pkg::DIV_CW'(1);
			end
		end
	end

	// Quotient bits shift into the low dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			low_q  <= low_init;
			dvsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= csc_pkg::DIV_W'(trial - {1'b0, dvsr_q});
			end else begin
				rem_q <= trial[csc_pkg::DIV_W-1:0];
			end
			low_q <= {low_q[csc_pkg::DIV_Q-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quot      = low_q;

endmodule

// ===== rtl/csc_front.sv =====
module csc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_packet,
	input  csc_pkg::fifo_stat_t   fstat,
	output logic                  push,
	output csc_pkg::pkt_rec_t     rec
);

	logic [3:0]  pos_q;
	logic [1:0]  flags_q;
	logic [31:0] wc_q;
	logic [15:0] wt_q;
	logic [15:0] cc_q;
	logic [15:0] ct_q;

	logic [3:0]  pos_n;
	logic [1:0]  flags_n;
	logic [31:0] wc_n;
	logic [15:0] wt_n;
	logic [15:0] cc_n;
	logic [15:0] ct_n;
	logic [3:0]  d;
	logic [3:0]  cb;
	logic [3:0]  c;
	logic [3:0]  cb_n;
	logic        acc;

	assign byte_ready = !fstat.full;
	assign acc        = byte_valid && byte_ready;
	assign push       = acc && end_of_packet;

	// Place the byte into its field lane
	always_comb begin
		flags_n = flags_q;
		wc_n    = wc_q;
		wt_n    = wt_q;
		cc_n    = cc_q;
		ct_n    = ct_q;
		d       = pos_q - 4'd1;
		cb      = flags_q[csc_pkg::FLAG_WHEEL] ? csc_pkg::WHEEL_BYTES : 4'd0;
		c       = d - cb;
		if (pos_q == 4'd0) begin
			flags_n = data_byte[1:0];
			wc_n    = '0;
			wt_n    = '0;
			cc_n    = '0;
			ct_n    = '0;
		end else if (flags_q[csc_pkg::FLAG_WHEEL] && d < csc_pkg::WHEEL_BYTES) begin
			if (d < 4'd4) begin
				wc_n[{d[1:0], 3'b000} +: 8] = data_byte;
			end else begin
				wt_n[{d[0], 3'b000} +: 8] = data_byte;
			end
		end else if (flags_q[csc_pkg::FLAG_CRANK] && d >= cb &&
			     d < cb + csc_pkg::CRANK_BYTES) begin
			if (c < 4'd2) begin
				cc_n[{c[0], 3'b000} +: 8] = data_byte;
			end else begin
				ct_n[{c[0], 3'b000} +: 8] = data_byte;
			end
		end
		pos_n = (pos_q == csc_pkg::POS_MAX) ? pos_q : pos_q + 4'd1;
		cb_n  = flags_n[csc_pkg::FLAG_WHEEL] ? csc_pkg::WHEEL_BYTES : 4'd0;
	end

	// Check section completeness at the last byte
	always_comb begin
		rec.wheel_ok    = flags_n[csc_pkg::FLAG_WHEEL] &&
				  (pos_n >= csc_pkg::WHEEL_BYTES + 4'd1);
		rec.crank_ok    = flags_n[csc_pkg::FLAG_CRANK] &&
				  (pos_n >= cb_n + csc_pkg::CRANK_BYTES + 4'd1);
		rec.short_pkt   = (flags_n[csc_pkg::FLAG_WHEEL] && !rec.wheel_ok) ||
				  (flags_n[csc_pkg::FLAG_CRANK] && !rec.crank_ok);
		rec.wheel_count = wc_n;
		rec.wheel_time  = wt_n;
		rec.crank_count = cc_n;
		rec.crank_time  = ct_n;
	end

	// Advance byte position; restart at the flags byte after a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '0;
		end else if (acc) begin
			if (end_of_packet) begin
				pos_q   <= '0;
				flags_q <= '0;
			end else begin
				pos_q   <= pos_n;
				flags_q <= flags_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			wc_q <= wc_n;
			wt_q <= wt_n;
			cc_q <= cc_n;
			ct_q <= ct_n;
		end
	end

`ifndef SYNTHESIS
	a_restart_after_eop: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (pos_q == 4'd0 && flags_q == 2'd0))
		else $error("front end did not restart after the last byte");
`endif

endmodule

// ===== rtl/csc_fifo.sv =====
module csc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  csc_pkg::pkt_rec_t    wr_rec,
	input  logic                 pop,
	output csc_pkg::pkt_rec_t    rd_rec,
	output csc_pkg::fifo_stat_t  stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	csc_pkg::pkt_rec_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_rec     = mem_q[rd_ptr_q];

	// Advance pointers with wrap and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("packet queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("packet queue read while empty");
`endif

endmodule

// ===== rtl/csc_back.sv =====
module csc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csc_pkg::cfg_t        cfg,
	input  csc_pkg::fifo_stat_t  fstat,
	input  csc_pkg::pkt_rec_t    rd_rec,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [15:0]          speed_centi_kmh,
	output logic                 speed_known,
	output logic [14:0]          cadence_centi_rpm,
	output logic                 cadence_known,
	output logic                 short_packet
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_WHEEL  = 11'b000_0000_0010,
		S_WSCALE = 11'b000_0000_0100,
		S_WCHK   = 11'b000_0000_1000,
		S_WDIV   = 11'b000_0001_0000,
		S_CRANK  = 11'b000_0010_0000,
		S_CMIN   = 11'b000_0100_0000,
		S_CMAX   = 11'b000_1000_0000,
		S_CDEC   = 11'b001_0000_0000,
		S_CDIV   = 11'b010_0000_0000,
		S_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Measurement state
	logic [31:0] prior_wc_q;
	logic [15:0] prior_wt_q;
	logic [15:0] prior_cc_q;
	logic [15:0] prior_ct_q;
	logic [15:0] speed_q;
	logic        speed_valid_q;
	logic [14:0] cad_q;
	logic        cad_valid_q;
	logic [1:0]  miss_q;
	logic        result_valid_q;

	// Per-packet working registers
	logic [31:0] wrevs_q;
	logic [15:0] wdt_q;
	logic        wheel_do_q;
	logic [15:0] crevs_q;
	logic [15:0] cdt_q;
	logic        crank_act_q;
	logic        short_q;
	logic [47:0] mul_q;
	logic [47:0] wp_q;
	logic [22:0] wd_q;
	logic [38:0] cnum_q;
	logic        hit_q;

	// Output register
	logic [15:0] out_speed_q;
	logic        out_speed_valid_q;
	logic [14:0] out_cad_q;
	logic        out_cad_valid_q;
	logic        out_short_q;

	logic [31:0] wrevs_pop;
	logic [15:0] wdt_pop;
	logic [15:0] crevs_pop;
	logic [15:0] cdt_pop;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic        spd_over;
	logic        cnum_gt;
	logic [1:0]  miss_inc;
	logic        emit_load;

	logic                        div_start;
	logic [csc_pkg::DIV_W-1:0]   div_rem;
	logic [csc_pkg::DIV_Q-1:0]   div_low;
	logic [csc_pkg::DIV_W-1:0]   div_dvsr;
	logic [csc_pkg::DIV_Q-1:0]   div_quot;
	csc_pkg::div_stat_t          dstat;

	csc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.low_init (div_low),
		.divisor  (div_dvsr),
		.stat     (dstat),
		.quot     (div_quot)
	);

	assign pop       = (state_q == S_IDLE) && !fstat.empty;
	assign wrevs_pop = rd_rec.wheel_count - prior_wc_q;
	assign wdt_pop   = rd_rec.wheel_time - prior_wt_q;
	assign crevs_pop = rd_rec.crank_count - prior_cc_q;
	assign cdt_pop   = rd_rec.crank_time - prior_ct_q;
	assign miss_inc  = (miss_q == 2'd3) ? miss_q : miss_q + 2'd1;
	assign emit_load = (state_q == S_EMIT) && (!result_valid_q || result_ready);

	// Speed overflows 16 bits when revs*circ*9 >= 16 * dt * 100
	assign spd_over  = wp_q >= {21'd0, wd_q, 4'd0};
	assign cnum_gt   = cnum_q > {8'd0, mul_q[30:0]};

	// Steer the shared multiplier and divider by step
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_rem   = '0;
		div_low   = '0;
		div_dvsr  = '0;
		case (state_q)
			S_WHEEL: begin
				mul_a = wrevs_q;
				mul_b = {4'd0, cfg.wheel_circ};
			end
			S_WCHK: begin
				div_start = !spd_over;
				div_rem   = wp_q[26:4];
				div_low   = {wp_q[3:0], 12'd0};
				div_dvsr  = wd_q;
			end
			S_CRANK: begin
				mul_a = {16'd0, crevs_q};
				mul_b = csc_pkg::CAD_MUL;
			end
			S_CMIN: begin
				mul_a = {17'd0, cfg.cad_min};
				mul_b = cdt_q;
			end
			S_CMAX: begin
				mul_a = {17'd0, cfg.cad_max};
				mul_b = cdt_q;
			end
			S_CDEC: begin
				div_start = hit_q && !cnum_gt;
				div_rem   = cnum_q[38:16];
				div_low   = cnum_q[15:0];
				div_dvsr  = {7'd0, cdt_q};
			end
			default: begin
			end
		endcase
	end

	// Sequence one packet and update measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prior_wc_q     <= '0;
			prior_wt_q     <= '0;
			prior_cc_q     <= '0;
			prior_ct_q     <= '0;
			speed_q        <= '0;
			speed_valid_q  <= 1'b0;
			cad_q          <= '0;
			cad_valid_q    <= 1'b0;
			miss_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready && !emit_load) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!fstat.empty) begin
						if (rd_rec.wheel_ok) begin
							prior_wc_q <= rd_rec.wheel_count;
							prior_wt_q <= rd_rec.wheel_time;
						end
						if (rd_rec.crank_ok) begin
							prior_cc_q <= rd_rec.crank_count;
							prior_ct_q <= rd_rec.crank_time;
						end
						state_q <= S_WHEEL;
					end
				end
				S_WHEEL: begin
					state_q <= wheel_do_q ? S_WSCALE : S_CRANK;
				end
				S_WSCALE: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (spd_over) begin
						speed_q       <= csc_pkg::SPEED_SAT;
						speed_valid_q <= 1'b1;
						state_q       <= S_CRANK;
					end else begin
						state_q <= S_WDIV;
					end
				end
				S_WDIV: begin
					if (dstat.done) begin
						speed_q       <= div_quot;
						speed_valid_q <= 1'b1;
						state_q       <= S_CRANK;
					end
				end
				S_CRANK: begin
					if (!crank_act_q) begin
						state_q <= S_EMIT;
					end else if (cdt_q == 16'd0) begin
						if (miss_q > cfg.miss_limit) begin
							cad_q       <= '0;
							cad_valid_q <= 1'b1;
						end
						miss_q  <= miss_inc;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CMIN;
					end
				end
				S_CMIN: begin
					state_q <= S_CMAX;
				end
				S_CMAX: begin
					state_q <= S_CDEC;
				end
				S_CDEC: begin
					if (!hit_q) begin
						miss_q  <= miss_inc;
						state_q <= S_EMIT;
					end else begin
						miss_q  <= '0;
						state_q <= cnum_gt ? S_EMIT : S_CDIV;
					end
				end
				S_CDIV: begin
					if (dstat.done) begin
						cad_q       <= div_quot[14:0];
						cad_valid_q <= 1'b1;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working values and output payload
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (pop) begin
			wrevs_q     <= wrevs_pop;
			wdt_q       <= wdt_pop;
			wheel_do_q  <= rd_rec.wheel_ok && (prior_wt_q != 16'd0) && (wdt_pop != 16'd0);
			crevs_q     <= crevs_pop;
			cdt_q       <= cdt_pop;
			crank_act_q <= rd_rec.crank_ok && (prior_ct_q != 16'd0);
			short_q     <= rd_rec.short_pkt;
		end
		if (state_q == S_WSCALE) begin
			wp_q <= {mul_q[44:0], 3'd0} + mul_q;
			wd_q <= 23'(wdt_q) * csc_pkg::SPEED_DIV;
		end
		if (state_q == S_CMIN) begin
			cnum_q <= {mul_q[24:0], 14'd0};
		end
		if (state_q == S_CMAX) begin
			hit_q <= cnum_gt;
		end
		if (emit_load) begin
			out_speed_q       <= speed_q;
			out_speed_valid_q <= speed_valid_q;
			out_cad_q         <= cad_q;
			out_cad_valid_q   <= cad_valid_q;
			out_short_q       <= short_q;
		end
	end

	assign result_valid      = result_valid_q;
	assign speed_centi_kmh   = out_speed_q;
	assign speed_known       = out_speed_valid_q;
	assign cadence_centi_rpm = out_cad_q;
	assign cadence_known     = out_cad_valid_q;
	assign short_packet      = out_short_q;

`ifndef SYNTHESIS
	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !dstat.busy)
		else $error("divider started while busy");
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == S_WDIV || state_q == S_CDIV))
		else $error("divider finished outside a wait step");
	a_speed_known_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		speed_valid_q |=> speed_valid_q)
		else $error("speed valid dropped");
`endif

endmodule

// ===== rtl/cycling_speed_cadence_decoder.sv =====
// Bytes are taken one per cycle while the packet queue has room.
// The back end works on one packet at a time: up to two waits on the shared restoring
// divider (speed, then cadence) plus the multiply and compare steps, before the packet's
// result turns valid.
// Reset (arst_n low) clears all measurement state and the queue at once and
// loads the configuration registers with their default values.
module cycling_speed_cadence_decoder #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] speed_centi_kmh,
	output logic        speed_known,
	output logic [14:0] cadence_centi_rpm,
	output logic        cadence_known,
	output logic        short_packet,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	csc_pkg::cfg_t       cfg_q;
	csc_pkg::fifo_stat_t fstat;
	csc_pkg::pkt_rec_t   wr_rec;
	csc_pkg::pkt_rec_t   rd_rec;
	logic                push;
	logic                pop;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_circ <= csc_pkg::RST_WHEEL_CIRC;
			cfg_q.cad_max    <= csc_pkg::RST_CAD_MAX;
			cfg_q.cad_min    <= csc_pkg::RST_CAD_MIN;
			cfg_q.miss_limit <= csc_pkg::RST_MISS_LIMIT;
		end else if (cfg_we) begin
			case (csc_pkg::cfg_reg_t'(cfg_index))
				csc_pkg::REG_WHEEL_CIRC: cfg_q.wheel_circ <= cfg_data[11:0];
				csc_pkg::REG_CAD_MAX:    cfg_q.cad_max    <= cfg_data;
				csc_pkg::REG_CAD_MIN:    cfg_q.cad_min    <= cfg_data;
				csc_pkg::REG_MISS_LIMIT: cfg_q.miss_limit <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	csc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.fstat         (fstat),
		.push          (push),
		.rec           (wr_rec)
	);

	csc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.stat   (fstat)
	);

	csc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.fstat             (fstat),
		.rd_rec            (rd_rec),
		.pop               (pop),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.speed_centi_kmh   (speed_centi_kmh),
		.speed_known       (speed_known),
		.cadence_centi_rpm (cadence_centi_rpm),
		.cadence_known     (cadence_known),
		.short_packet      (short_packet)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int WHEEL_LEN = 6;
	localparam int CRANK_LEN = 4;
	localparam logic [63:0] SPEED_GAIN = 64'd36864;
	localparam logic [63:0] SPEED_DEN  = 64'd100;
	localparam logic [63:0] CAD_GAIN   = 64'd6144000;
	localparam logic [63:0] SPEED_CAP  = 64'd65535;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_BYTES = 95;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic [15:0] speed;
		logic        speed_known;
		logic [14:0] cadence;
		logic        cadence_known;
		logic        short_pkt;
	} reading_t;

	localparam reading_t NIL_RD   = '0;
	localparam reading_t SHORT_RD = 34'd1;

	typedef struct packed {
		logic [7:0]  flags;
		logic [31:0] wheel_revs;
		logic [15:0] wheel_tick;
		logic [15:0] crank_revs;
		logic [15:0] crank_tick;
		logic [4:0]  nbytes;
		logic        typed;
		reading_t    rd;
	} pkt_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
		logic       typed;
		reading_t   rd;
	} plan_byte_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  data_byte;
	logic        end_of_packet;
	logic        result_valid;
	logic        result_ready;
	logic [15:0] speed_centi_kmh;
	logic        speed_known;
	logic [14:0] cadence_centi_rpm;
	logic        cadence_known;
	logic        short_packet;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;

	cycling_speed_cadence_decoder u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.data_byte         (data_byte),
		.end_of_packet     (end_of_packet),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.speed_centi_kmh   (speed_centi_kmh),
		.speed_known       (speed_known),
		.cadence_centi_rpm (cadence_centi_rpm),
		.cadence_known     (cadence_known),
		.short_packet      (short_packet),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Decoder mirror: packet assembly, prior values, outputs, registers
	logic [3:0]  seq_pos;
	logic [1:0]  pkt_sel;
	logic [31:0] acc_wrev;
	logic [15:0] acc_wtick, acc_crev, acc_ctick;
	logic [31:0] last_wrev;
	logic [15:0] last_wtick, last_crev, last_ctick;
	logic [15:0] cur_speed;
	logic        have_speed;
	logic [14:0] cur_cad;
	logic        have_cad;
	logic [1:0]  miss_run;
	logic [11:0] circ_mm;
	logic [14:0] cad_hi, cad_lo;
	logic [1:0]  miss_cap;

	reading_t   pending_readings [$];
	plan_byte_t byte_plan [$];
	logic       cur_typed;
	reading_t   cur_rd;

	int  fail_count;
	int  bytes_taken;
	int  readings_seen;
	int  short_seen;
	int  packets_planned;
	bit  send_steady;
	bit  take_steady;
	bit  hold_ask;

	// Sensor-side counters for well-formed random packets
	logic [31:0] sim_wrev;
	logic [15:0] sim_wtick, sim_crev, sim_ctick;

	pkt_row_t directed_rows [0:25] = '{
		{8'h00, 32'h0,  16'h0,    16'h0,    16'h0,    5'd1,  1'b1, NIL_RD},
		{8'h03, 32'h0,  16'h0,    16'h0,    16'h0,    5'd1,  1'b1, SHORT_RD},
		{8'hFC, 32'h0,  16'h0,    16'h0,    16'h0,    5'd1,  1'b1, NIL_RD},
		// first wheel section: no prior time, so only the priors load
		{8'h01, 32'h10, 16'h0400, 16'h0,    16'h0,    5'd7,  1'b1, NIL_RD},
		{8'h01, 32'h11, 16'h0800, 16'h0,    16'h0,    5'd4,  1'b1, SHORT_RD},
		{8'h01, 32'h11, 16'h0800, 16'h0,    16'h0,    5'd7,  1'b0, NIL_RD},
		{8'h01, 32'h13, 16'h0800, 16'h0,    16'h0,    5'd7,  1'b0, NIL_RD},
		// count runs backwards by one: huge delta, saturated speed
		{8'h01, 32'h12, 16'h0801, 16'h0,    16'h0,    5'd7,  1'b0, NIL_RD},
		{8'h01, 32'h14, 16'hFFF0, 16'h0,    16'h0,    5'd7,  1'b0, NIL_RD},
		{8'h01, 32'h16, 16'h03F0, 16'h0,    16'h0,    5'd7,  1'b0, NIL_RD},
		// crank with zero time, then one with a zero prior time: no cadence work
		{8'h02, 32'h0,  16'h0,    16'h0010, 16'h0000, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h0020, 16'h0100, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h007A, 16'h0500, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h007B, 16'h0900, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h007B, 16'h0D00, 5'd5,  1'b0, NIL_RD},
		// repeated crank time until the miss run forces zero cadence
		{8'h02, 32'h0,  16'h0,    16'h007B, 16'h0D00, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h007B, 16'h0D00, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h007B, 16'h0D00, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'hFFFF, 16'h1100, 5'd5,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h0000, 16'h1500, 5'd5,  1'b0, NIL_RD},
		{8'h03, 32'h18, 16'h07F0, 16'h0001, 16'h1900, 5'd11, 1'b0, NIL_RD},
		// spare bytes past both sections, position saturates
		{8'h03, 32'h1A, 16'h0BF0, 16'h0002, 16'h1D00, 5'd20, 1'b0, NIL_RD},
		{8'h03, 32'h1C, 16'h0FF0, 16'h0003, 16'h2100, 5'd9,  1'b0, NIL_RD},
		{8'h02, 32'h0,  16'h0,    16'h0009, 16'h0000, 5'd3,  1'b0, NIL_RD},
		{8'h01, 32'h0,  16'h0,    16'h0,    16'h0,    5'd1,  1'b0, NIL_RD},
		// cadence exactly at the low bound counts as a miss
		{8'h02, 32'h0,  16'h0,    16'h0003, 16'h0D00, 5'd5,  1'b0, NIL_RD}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("cycling_speed_cadence_decoder verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] tick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 16'd0;
		if (r < 90) return 16'($urandom_range(200, 4000));
		return 16'($urandom);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			fail_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic reset_mirror();
		seq_pos = '0;
		pkt_sel = '0;
		acc_wrev = '0;
		acc_wtick = '0;
		acc_crev = '0;
		acc_ctick = '0;
		last_wrev = '0;
		last_wtick = '0;
		last_crev = '0;
		last_ctick = '0;
		cur_speed = '0;
		have_speed = 1'b0;
		cur_cad = '0;
		have_cad = 1'b0;
		miss_run = '0;
		circ_mm = 12'd2095;
		cad_hi = 15'd20000;
		cad_lo = 15'd100;
		miss_cap = 2'd2;
	endtask

	task automatic bump_miss_run();
		if (miss_run != 2'd3)
			miss_run = miss_run + 2'd1;
	endtask

	// Advance the mirror by one byte; report a reading at the end of a packet
	task automatic decode_byte(input logic [7:0] b, input logic eop,
			output bit got, output reading_t rd);
		int d;
		int cbase;
		logic [15:0] dt;
		logic [31:0] wdelta;
		logic [15:0] cdelta;
		logic [63:0] num;
		logic [63:0] quo;
		bit shortp;

		got = 0;
		rd = NIL_RD;
		shortp = 0;
		cbase = pkt_sel[csc_pkg::FLAG_WHEEL] ? WHEEL_LEN : 0;
		if (seq_pos == 0) begin
			pkt_sel = b[1:0];
			acc_wrev = '0;
			acc_wtick = '0;
			acc_crev = '0;
			acc_ctick = '0;
			cbase = pkt_sel[csc_pkg::FLAG_WHEEL] ? WHEEL_LEN : 0;
		end else begin
			d = int'(seq_pos) - 1;
			if (pkt_sel[csc_pkg::FLAG_WHEEL] && d < WHEEL_LEN) begin
				if (d < 4) acc_wrev[8*d +: 8] = b;
				else acc_wtick[8*(d-4) +: 8] = b;
			end else if (pkt_sel[csc_pkg::FLAG_CRANK] && d >= cbase &&
					d < cbase + CRANK_LEN) begin
				if (d - cbase < 2) acc_crev[8*(d-cbase) +: 8] = b;
				else acc_ctick[8*(d-cbase-2) +: 8] = b;
			end
		end
		if (seq_pos != 4'd15)
			seq_pos = seq_pos + 4'd1;
		if (!eop) return;

		// Wheel section: speed from revolution and time deltas
		if (pkt_sel[csc_pkg::FLAG_WHEEL]) begin
			if (int'(seq_pos) >= 1 + WHEEL_LEN) begin
				if (last_wtick != 0) begin
					dt = acc_wtick - last_wtick;
					if (dt != 0) begin
						wdelta = acc_wrev - last_wrev;
						num = 64'(wdelta) * 64'(circ_mm) * SPEED_GAIN;
						quo = num / (64'(dt) * SPEED_DEN);
						cur_speed = (quo > SPEED_CAP) ? 16'hFFFF : quo[15:0];
						have_speed = 1'b1;
					end
				end
				last_wrev = acc_wrev;
				last_wtick = acc_wtick;
			end else begin
				shortp = 1;
			end
		end

		// Crank section: cadence with bounds and the miss run
		if (pkt_sel[csc_pkg::FLAG_CRANK]) begin
			if (int'(seq_pos) >= 1 + cbase + CRANK_LEN) begin
				if (last_ctick != 0) begin
					dt = acc_ctick - last_ctick;
					if (dt != 0) begin
						cdelta = acc_crev - last_crev;
						num = 64'(cdelta) * CAD_GAIN;
						if (num > 64'(cad_lo) * 64'(dt)) begin
							if (!(num > 64'(cad_hi) * 64'(dt))) begin
								quo = num / 64'(dt);
								cur_cad = quo[14:0];
								have_cad = 1'b1;
							end
							miss_run = '0;
						end else begin
							bump_miss_run();
						end
					end else begin
						if (miss_run > miss_cap) begin
							cur_cad = '0;
							have_cad = 1'b1;
						end
						bump_miss_run();
					end
				end
				last_crev = acc_crev;
				last_ctick = acc_ctick;
			end else begin
				shortp = 1;
			end
		end

		seq_pos = '0;
		pkt_sel = '0;
		got = 1;
		rd = '{cur_speed, have_speed, cur_cad, have_cad, shortp};
	endtask

	// Serialize one packet into the byte plan, padding or cutting to nbytes
	task automatic queue_packet(input logic [7:0] flags, input logic [31:0] wrev,
			input logic [15:0] wtick, input logic [15:0] crev, input logic [15:0] ctick,
			input int nbytes, input logic typed, input reading_t rd);
		logic [7:0] raw [$];
		plan_byte_t pb;

		raw.push_back(flags);
		if (flags[csc_pkg::FLAG_WHEEL]) begin
			for (int k = 0; k < 4; k++) raw.push_back(wrev[8*k +: 8]);
			for (int k = 0; k < 2; k++) raw.push_back(wtick[8*k +: 8]);
		end
		if (flags[csc_pkg::FLAG_CRANK]) begin
			for (int k = 0; k < 2; k++) raw.push_back(crev[8*k +: 8]);
			for (int k = 0; k < 2; k++) raw.push_back(ctick[8*k +: 8]);
		end
		for (int i = 0; i < nbytes; i++) begin
			pb.data = (i < raw.size()) ? raw[i] : 8'($urandom);
			pb.eop = (i == nbytes - 1);
			pb.typed = pb.eop ? typed : 1'b0;
			pb.rd = rd;
			byte_plan.push_back(pb);
		end
		packets_planned++;
	endtask

	// Mostly well-formed packets from a moving sensor, mixed with cut ones and noise
	task automatic plan_random_packets(input int budget);
		int r;
		int nat;
		int nb;
		logic [1:0] kind;
		logic [7:0] fl;

		while (byte_plan.size() < budget) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0) kind = 2'd0;
			else if ($urandom_range(0, 2) == 0) kind = 2'($urandom_range(1, 2));
			else kind = 2'd3;
			fl = {6'($urandom), kind};
			if ($urandom_range(0, 99) < 85) sim_wrev = sim_wrev + $urandom_range(0, 8);
			else if ($urandom_range(0, 1) == 0) sim_wrev = sim_wrev + $urandom_range(9, 4000);
			else sim_wrev = sim_wrev + $urandom;
			if ($urandom_range(0, 99) < 85) sim_crev = sim_crev + 16'($urandom_range(0, 3));
			else sim_crev = sim_crev + 16'($urandom);
			sim_wtick = ($urandom_range(0, 39) == 0) ? 16'd0 : sim_wtick + tick_step();
			sim_ctick = ($urandom_range(0, 39) == 0) ? 16'd0 : sim_ctick + tick_step();
			nat = 1 + (kind[0] ? WHEEL_LEN : 0) + (kind[1] ? CRANK_LEN : 0);
			if (r < 78) begin
				nb = nat + (($urandom_range(0, 6) == 0) ? $urandom_range(1, 9) : 0);
				queue_packet(fl, sim_wrev, sim_wtick, sim_crev, sim_ctick, nb, 1'b0, NIL_RD);
			end else if (r < 90) begin
				nb = (nat > 1) ? $urandom_range(1, nat - 1) : 1;
				queue_packet(fl, sim_wrev, sim_wtick, sim_crev, sim_ctick, nb, 1'b0, NIL_RD);
			end else begin
				queue_packet(8'($urandom), $urandom, 16'($urandom), 16'($urandom),
					16'($urandom), $urandom_range(1, 20), 1'b0, NIL_RD);
			end
		end
	endtask

	// Offer every planned byte request, with random gaps between them unless sending steadily
	task automatic send_plan();
		int gap;
		plan_byte_t pb;

		while (byte_plan.size() != 0) begin
			pb = byte_plan.pop_front();
			gap = send_steady ? 0 : pick_gap();
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_valid <= 1'b1;
			data_byte <= pb.data;
			end_of_packet <= pb.eop;
			cur_typed <= pb.typed;
			cur_rd <= pb.rd;
			@(posedge clk);
			while (!byte_ready) @(posedge clk);
		end
		byte_valid <= 1'b0;
	endtask

	// Wait for every expected reading, then let the back end drain
	task automatic settle();
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [11:0] circ, input logic [14:0] hi,
			input logic [14:0] lo, input logic [1:0] cap);
		logic [14:0] vals [4];

		vals[csc_pkg::REG_WHEEL_CIRC] = 15'(circ);
		vals[csc_pkg::REG_CAD_MAX] = hi;
		vals[csc_pkg::REG_CAD_MIN] = lo;
		vals[csc_pkg::REG_MISS_LIMIT] = 15'(cap);
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= csc_pkg::cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		circ_mm = circ;
		cad_hi = hi;
		cad_lo = lo;
		miss_cap = cap;
	endtask

	// Predict on each byte request taken, check each reading taken
	always @(posedge clk) begin
		bit got;
		reading_t rd;
		reading_t want;

		if (arst_n && byte_valid && byte_ready) begin
			bytes_taken++;
			decode_byte(data_byte, end_of_packet, got, rd);
			if (got) pending_readings.push_back(cur_typed ? cur_rd : rd);
		end
		if (arst_n && result_valid && result_ready) begin
			readings_seen++;
			if (short_packet) short_seen++;
			if (pending_readings.size() == 0) begin
				fail_count++;
				$display("%0t ns: unexpected reading, expected none, got speed %0d cadence %0d",
					$time, speed_centi_kmh, cadence_centi_rpm);
			end else begin
				want = pending_readings.pop_front();
				check_field("speed_centi_kmh", want.speed, speed_centi_kmh);
				check_field("speed_known", want.speed_known, speed_known);
				check_field("cadence_centi_rpm", want.cadence, cadence_centi_rpm);
				check_field("cadence_known", want.cadence_known, cadence_known);
				check_field("short_packet", want.short_pkt, short_packet);
			end
		end
	end

	// Result side: random stalls, steady taking when asked, or one long hold-off when asked
	initial begin
		int stall_left;
		int hold_left;

		stall_left = 0;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_ask) begin
				hold_ask = 0;
				hold_left = LONG_HOLD;
				result_ready <= 1'b0;
			end else if (take_steady) begin
				result_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [11:0] circ;
		logic [14:0] hi, lo;
		logic [1:0]  cap;

		fail_count = 0;
		bytes_taken = 0;
		readings_seen = 0;
		short_seen = 0;
		packets_planned = 0;
		send_steady = 0;
		take_steady = 0;
		hold_ask = 0;
		sim_wrev = $urandom;
		sim_wtick = 16'($urandom);
		sim_crev = 16'($urandom);
		sim_ctick = 16'($urandom);
		reset_mirror();
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		data_byte <= '0;
		end_of_packet <= 1'b0;
		cur_typed <= 1'b0;
		cur_rd <= NIL_RD;
		cfg_we <= 1'b0;
		cfg_index <= csc_pkg::REG_WHEEL_CIRC;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed packets at the default register values
		for (int i = 0; i < $size(directed_rows); i++) begin
			queue_packet(directed_rows[i].flags, directed_rows[i].wheel_revs,
				directed_rows[i].wheel_tick, directed_rows[i].crank_revs,
				directed_rows[i].crank_tick, int'(directed_rows[i].nbytes),
				directed_rows[i].typed, directed_rows[i].rd);
		end
		send_plan();

		// Random phases, each under its own register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					circ = 12'd4095; hi = 15'd30000; lo = 15'd0; cap = 2'd0;
				end
				1: begin
					circ = 12'd100; hi = 15'd0; lo = 15'd30000; cap = 2'd3;
				end
				2: begin
					circ = 12'd2095; hi = 15'd20000; lo = 15'd100; cap = 2'd1;
				end
				default: begin
					circ = 12'($urandom_range(100, 4095));
					lo = 15'($urandom_range(0, 5000));
					hi = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(0, 30000))
						: 15'($urandom_range(int'(lo), 30000));
					cap = 2'($urandom_range(0, 3));
				end
			endcase
			set_config(circ, hi, lo, cap);
			send_steady = (p == 2 || p == 3);
			take_steady = (p == 3);
			if (p == 2) hold_ask = 1;
			plan_random_packets(PHASE_BYTES);
			send_plan();
		end
		settle();

		$display("Run took %0d bytes in %0d packets over %0d register settings;",
			bytes_taken, packets_planned, NUM_PHASES + 1);
		$display("%0d readings checked, %0d of them flagged short", readings_seen, short_seen);
		if (fail_count == 0 && pending_readings.size() == 0) begin
			$display("cycling_speed_cadence_decoder verification clean");
		end else begin
			$display("cycling_speed_cadence_decoder verification failed");
		end
		$finish;
	end

endmodule
